// ===== sv/vrpv_pkg.sv =====
package vrpv_pkg;

	localparam int TRIG_WIDTH    = 16;
	localparam int TRIG_FRAC     = 14;
	localparam int DIM_WIDTH     = 12;
	localparam int CFG_IDX_WIDTH = 2;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_COS    = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SIN    = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_HALF_W = 2'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_HALF_H = 2'd3;

	localparam logic [TRIG_WIDTH-1:0] COS_RESET  = 16'd16384;
	localparam logic [TRIG_WIDTH-1:0] SIN_RESET  = 16'd0;
	localparam logic [DIM_WIDTH-1:0]  HALF_RESET = 12'd325;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_DIV_ZERO = 2'd1;
	localparam status_t ST_SAT      = 2'd2;

endpackage

// ===== sv/vertex_rotate_project_viewport.sv =====
// channel   signals                                      dir
// request   in_valid in_ready vert_x vert_y vert_z       in
// result    out_valid out_ready screen_x screen_y status out
// config    cfg_write cfg_index cfg_data                 in
//
// one request per clock unless a low out_ready backs the pipeline up; four arithmetic stages,
// an overflow check stage, one restoring divide stage per quotient bit, output register
// arst_n clears all stage valid bits and loads the register reset values
// each stage holds only when it is full and the stage after it holds, so bubbles
// close up and in_ready drops only once every stage is full and out_ready is low
module vertex_rotate_project_viewport import vrpv_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [CFG_IDX_WIDTH-1:0]        cfg_index,
	input  logic [TRIG_WIDTH-1:0]           cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [COORD_WIDTH-1:0]   vert_x,
	input  logic signed [COORD_WIDTH-1:0]   vert_y,
	input  logic signed [COORD_WIDTH-1:0]   vert_z,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [COORD_WIDTH-1:0]   screen_x,
	output logic signed [COORD_WIDTH-1:0]   screen_y,
	output status_t                         status
);

	localparam int W   = COORD_WIDTH;
	localparam int PW  = W + TRIG_WIDTH;
	localparam int DW  = ((W + 17 > FRAC_BITS + TRIG_FRAC + 2) ?
		W + 17 : FRAC_BITS + TRIG_FRAC + 2) + 1;
	localparam int AW  = DW + 1;
	localparam int NW  = AW + DIM_WIDTH + 1;
	localparam int RW  = (NW > DW + W) ? NW : DW + W;
	localparam int NS  = W + 6;
	localparam int OUT = NS - 1;

	localparam logic signed [DW-1:0] ONE     = {{(DW-1){1'b0}}, 1'b1} << (FRAC_BITS + TRIG_FRAC);
	localparam logic [W-1:0]         POS_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]         NEG_MAG = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic [RW-1:0] rem_x;
		logic [RW-1:0] rem_y;
		logic [DW-1:0] dm;
		logic [W-1:0]  q_x;
		logic [W-1:0]  q_y;
		logic          neg_x;
		logic          neg_y;
		logic          ovf_x;
		logic          ovf_y;
		logic          dz;
	} div_t;

	function automatic logic [W:0] clamp_q(input logic [W-1:0] q, input logic ovf,
		input logic neg);
		logic [W:0] r;
		if (!neg) begin
			if (ovf || q > POS_MAX) r = {1'b1, POS_MAX};
			else r = {1'b0, q};
		end else begin
			if (ovf || q > NEG_MAG) r = {1'b1, NEG_MAG};
			else r = {1'b0, ~q + {{(W-1){1'b0}}, 1'b1}};
		end
		return r;
	endfunction

	logic signed [TRIG_WIDTH-1:0] cos_q, sin_q;
	logic [DIM_WIDTH-1:0]         half_w_q, half_h_q;

	logic [NS-1:0] vld, adv;

	logic signed [PW-1:0] xc_s1, zs_s1, xs_s1, zc_s1;
	logic signed [W-1:0]  y_s1;
	logic signed [DW-1:0] rx_s2, d_s2, ys_s2;
	logic signed [NW-1:0] nx_s3, ny_s3;
	logic signed [DW-1:0] d_s3;
	logic [NW-1:0]        nxm_s4, nym_s4;
	logic [DW-1:0]        dm_s4;
	logic                 negx_s4, negy_s4, dz_s4;
	div_t                 div_s [0:W];
	logic [W-1:0]         sx_q, sy_q;
	status_t              st_q;

	logic signed [AW-1:0] sum_x, sum_y;
	logic [W:0]           cl_x, cl_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q    <= COS_RESET;
			sin_q    <= SIN_RESET;
			half_w_q <= HALF_RESET;
			half_h_q <= HALF_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_COS:    cos_q    <= cfg_data;
				REG_SIN:    sin_q    <= cfg_data;
				REG_HALF_W: half_w_q <= cfg_data[DIM_WIDTH-1:0];
				REG_HALF_H: half_h_q <= cfg_data[DIM_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// stage advance chain, from the output back
	assign adv[OUT] = !vld[OUT] || out_ready;
	for (genvar i = 0; i < OUT; i++) begin : g_adv
		assign adv[i] = !vld[i] || adv[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (adv[0]) vld[0] <= in_valid;
			for (int i = 1; i < NS; i++) begin
				if (adv[i]) vld[i] <= vld[i-1];
			end
		end
	end

	assign in_ready = adv[0];

	// rotation products
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			xc_s1 <= vert_x * cos_q;
			zs_s1 <= vert_z * sin_q;
			xs_s1 <= vert_x * sin_q;
			zc_s1 <= vert_z * cos_q;
			y_s1  <= vert_y;
		end
	end

	// rotated x, divisor, scaled y
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			rx_s2 <= DW'(xc_s1) - DW'(zs_s1);
			d_s2  <= DW'(xs_s1) + DW'(zc_s1) + ONE;
			ys_s2 <= DW'(y_s1) <<< TRIG_FRAC;
		end
	end

	// numerators
	assign sum_x = AW'(rx_s2) + AW'(d_s2);
	assign sum_y = AW'(d_s2) - AW'(ys_s2);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			nx_s3 <= sum_x * $signed({1'b0, half_w_q});
			ny_s3 <= sum_y * $signed({1'b0, half_h_q});
			d_s3  <= d_s2;
		end
	end

	// sign and magnitude
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			nxm_s4  <= nx_s3[NW-1] ? NW'(-nx_s3) : NW'(nx_s3);
			nym_s4  <= ny_s3[NW-1] ? NW'(-ny_s3) : NW'(ny_s3);
			dm_s4   <= d_s3[DW-1] ? DW'(-d_s3) : DW'(d_s3);
			negx_s4 <= nx_s3[NW-1] ^ d_s3[DW-1];
			negy_s4 <= ny_s3[NW-1] ^ d_s3[DW-1];
			dz_s4   <= (d_s3 == '0);
		end
	end

	// quotient range check
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			div_s[0].rem_x <= RW'(nxm_s4);
			div_s[0].rem_y <= RW'(nym_s4);
			div_s[0].dm    <= dm_s4;
			div_s[0].q_x   <= '0;
			div_s[0].q_y   <= '0;
			div_s[0].neg_x <= negx_s4;
			div_s[0].neg_y <= negy_s4;
			div_s[0].ovf_x <= RW'(nxm_s4) >= (RW'(dm_s4) << W);
			div_s[0].ovf_y <= RW'(nym_s4) >= (RW'(dm_s4) << W);
			div_s[0].dz    <= dz_s4;
		end
	end

	// restoring divide, one quotient bit per stage
	for (genvar j = 1; j <= W; j++) begin : g_div
		localparam int K = W - j;
		div_t          nxt;
		logic [RW-1:0] dsh;

		assign dsh = RW'(div_s[j-1].dm) << K;

		always_comb begin
			nxt = div_s[j-1];
			if (nxt.rem_x >= dsh) begin
				nxt.rem_x  = nxt.rem_x - dsh;
				nxt.q_x[K] = 1'b1;
			end
			if (nxt.rem_y >= dsh) begin
				nxt.rem_y  = nxt.rem_y - dsh;
				nxt.q_y[K] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[4+j]) div_s[j] <= nxt;
		end
	end

	// sign, clamp, status
	assign cl_x = clamp_q(div_s[W].q_x, div_s[W].ovf_x, div_s[W].neg_x);
	assign cl_y = clamp_q(div_s[W].q_y, div_s[W].ovf_y, div_s[W].neg_y);

	always_ff @(posedge clk) begin
		if (adv[OUT]) begin
			if (div_s[W].dz) begin
				sx_q <= '0;
				sy_q <= '0;
				st_q <= ST_DIV_ZERO;
			end else begin
				sx_q <= cl_x[W-1:0];
				sy_q <= cl_y[W-1:0];
				st_q <= (cl_x[W] || cl_y[W]) ? ST_SAT : ST_OK;
			end
		end
	end

	assign out_valid = vld[OUT];
	assign screen_x  = sx_q;
	assign screen_y  = sy_q;
	assign status    = st_q;

`ifndef SYNTH
	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low with empty output register");

	a_div_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DIV_ZERO |-> screen_x == '0 && screen_y == '0)
		else $error("zero divisor result not cleared");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SAT |->
		sx_q == POS_MAX || sx_q == NEG_MAG || sy_q == POS_MAX || sy_q == NEG_MAG)
		else $error("saturation flagged without a clamped coordinate");
`endif

endmodule

// ===== tb/sv/vertex_rotate_project_viewport_tb.sv =====
module vertex_rotate_project_viewport_tb;
	import vrpv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     CW        = 16;
	localparam int     FB        = 12;
	localparam longint UNITY     = longint'(1) << (FB + TRIG_FRAC);
	localparam int     CYCLE_CAP = 200000;
	localparam int     HOLD_LEN  = 250;
	localparam int     HOLD_AT   = 300;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} vertex_t;

	typedef struct {
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		status_t              st;
	} screen_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_write = 1'b0;
	logic [CFG_IDX_WIDTH-1:0]   cfg_index = REG_COS;
	logic [TRIG_WIDTH-1:0]      cfg_data  = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic signed [CW-1:0]       vert_x    = '0;
	logic signed [CW-1:0]       vert_y    = '0;
	logic signed [CW-1:0]       vert_z    = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [CW-1:0]       screen_x;
	logic signed [CW-1:0]       screen_y;
	status_t                    status;

	logic signed [TRIG_WIDTH-1:0] cos_q  = COS_RESET;
	logic signed [TRIG_WIDTH-1:0] sin_q  = SIN_RESET;
	logic [DIM_WIDTH-1:0]         half_w = HALF_RESET;
	logic [DIM_WIDTH-1:0]         half_h = HALF_RESET;

	vertex_t vertex_q[$];
	screen_t screen_q[$];
	int      cycle_cnt = 0;
	int      req_cnt   = 0;
	int      err_cnt   = 0;
	int      hold_left = 0;
	bit      hold_used = 1'b0;

	vertex_rotate_project_viewport #(
		.COORD_WIDTH(CW),
		.FRAC_BITS  (FB)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.vert_x   (vert_x),
		.vert_y   (vert_y),
		.vert_z   (vert_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.screen_x (screen_x),
		.screen_y (screen_y),
		.status   (status)
	);

	always #5 clk = ~clk;

	function automatic bit calm_now();
		return (cycle_cnt % 6000) < 1500;
	endfunction

	function automatic screen_t project_vertex(input logic signed [CW-1:0] vx,
		input logic signed [CW-1:0] vy, input logic signed [CW-1:0] vz);
		screen_t r;
		longint  rx, rz, d, px, py, hi, lo;
		bit      clip;
		rx   = longint'(vx) * longint'(cos_q) - longint'(vz) * longint'(sin_q);
		rz   = longint'(vx) * longint'(sin_q) + longint'(vz) * longint'(cos_q);
		d    = rz + UNITY;
		hi   = (longint'(1) << (CW - 1)) - 1;
		lo   = -hi - 1;
		clip = 1'b0;
		if (d == 0) begin
			r.sx = '0;
			r.sy = '0;
			r.st = ST_DIV_ZERO;
		end else begin
			px = ((rx + d) * longint'(half_w)) / d;
			py = ((d - longint'(vy) * (longint'(1) << TRIG_FRAC)) * longint'(half_h)) / d;
			if (px > hi) begin
				px = hi;
				clip = 1'b1;
			end else if (px < lo) begin
				px = lo;
				clip = 1'b1;
			end
			if (py > hi) begin
				py = hi;
				clip = 1'b1;
			end else if (py < lo) begin
				py = lo;
				clip = 1'b1;
			end
			r.sx = px[CW-1:0];
			r.sy = py[CW-1:0];
			r.st = clip ? ST_SAT : ST_OK;
		end
		return r;
	endfunction

	// mostly random, part aimed at or next to the zero-divisor point
	function automatic vertex_t make_vertex();
		vertex_t v;
		longint  c, s, need, t;
		int      pick, k;
		bit      hit;
		c      = longint'(cos_q);
		s      = longint'(sin_q);
		hit    = 1'b0;
		v.x    = CW'($urandom);
		v.y    = CW'($urandom);
		v.z    = CW'($urandom);
		pick   = $urandom_range(0, 99);
		if (pick < 35) begin
			for (k = 0; k < 16 && !hit; k++) begin
				if (c != 0) begin
					need = -UNITY - longint'(v.x) * s;
					if (need % c == 0) begin
						t = need / c;
						if (t >= -32768 && t <= 32767) begin
							v.z = t[CW-1:0];
							hit = 1'b1;
						end
					end
				end else if (s != 0) begin
					need = -UNITY;
					if (need % s == 0) begin
						t = need / s;
						if (t >= -32768 && t <= 32767) begin
							v.x = t[CW-1:0];
							hit = 1'b1;
						end
					end
				end
				if (!hit)
					v.x = CW'($urandom);
			end
			if (hit && pick >= 15) begin
				t = longint'(v.z) + longint'($urandom_range(0, 16)) - 8;
				if (t >= -32768 && t <= 32767)
					v.z = t[CW-1:0];
			end
		end
		return v;
	endfunction

	task automatic queue_vertex(input int x, input int y, input int z);
		vertex_t v;
		v.x = x[CW-1:0];
		v.y = y[CW-1:0];
		v.z = z[CW-1:0];
		vertex_q.push_back(v);
	endtask

	task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
		input logic [TRIG_WIDTH-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_COS:    cos_q  = val;
			REG_SIN:    sin_q  = val;
			REG_HALF_W: half_w = val[DIM_WIDTH-1:0];
			REG_HALF_H: half_h = val[DIM_WIDTH-1:0];
			default:    ;
		endcase
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (vertex_q.size() != 0 || in_valid || screen_q.size() != 0);
	endtask

	task automatic run_phase(input int c, input int s, input int hw, input int hh,
		input int n);
		write_reg(REG_COS, c[TRIG_WIDTH-1:0]);
		write_reg(REG_SIN, s[TRIG_WIDTH-1:0]);
		write_reg(REG_HALF_W, hw[TRIG_WIDTH-1:0]);
		write_reg(REG_HALF_H, hh[TRIG_WIDTH-1:0]);
		@(posedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
		repeat (n)
			vertex_q.push_back(make_vertex());
		wait_drained();
	endtask

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_CAP) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin : drive
		vertex_t nxt;
		screen_t want;
		bit      go;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				want = project_vertex(vert_x, vert_y, vert_z);
				screen_q.push_back(want);
				req_cnt <= req_cnt + 1;
			end
			if (!in_valid || in_ready) begin
				go = vertex_q.size() > 0 && (calm_now() || $urandom_range(0, 99) >= 18);
				if (go) begin
					nxt = vertex_q.pop_front();
					vert_x <= nxt.x;
					vert_y <= nxt.y;
					vert_z <= nxt.z;
				end
				in_valid <= go;
			end
		end
	end

	always @(posedge clk) begin : observe
		screen_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (screen_q.size() == 0) begin
					if (err_cnt < 10)
						$display("unexpected result: x=%0d y=%0d st=%0d",
							screen_x, screen_y, status);
					err_cnt++;
				end else begin
					want = screen_q.pop_front();
					if (screen_x !== want.sx || screen_y !== want.sy || status !== want.st) begin
						if (err_cnt < 10)
							$display("mismatch: expected x=%0d y=%0d st=%0d got x=%0d y=%0d st=%0d",
								want.sx, want.sy, want.st, screen_x, screen_y, status);
						err_cnt++;
					end
				end
			end
			// one long receiver stall so the pipeline backs up into in_ready
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!hold_used && req_cnt >= HOLD_AT) begin
				hold_used <= 1'b1;
				hold_left <= HOLD_LEN;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm_now() || $urandom_range(0, 99) >= 18;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		queue_vertex(0, 0, 0);
		queue_vertex(32767, 32767, 32767);
		queue_vertex(-32768, -32768, -32768);
		queue_vertex(32767, -32768, 0);
		queue_vertex(-32768, 32767, 0);
		queue_vertex(0, 0, 32767);
		queue_vertex(0, 0, -32768);
		// divisor exactly zero
		queue_vertex(0, 0, -4096);
		queue_vertex(12345, -777, -4096);
		// tiny divisor, clamps on each bound
		queue_vertex(32767, 0, -4095);
		queue_vertex(-32768, 0, -4095);
		queue_vertex(0, 32767, -4095);
		queue_vertex(0, -32768, -4095);
		queue_vertex(0, 0, -4097);
		queue_vertex(4096, 4096, 0);
		queue_vertex(-1, -1, -1);
		queue_vertex(21845, 21845, 21845);
		queue_vertex(-21846, -21846, -21846);
		repeat (200)
			vertex_q.push_back(make_vertex());
		wait_drained();

		run_phase(16384, 0, 4095, 4095, 225);
		run_phase(-16384, 0, 1, 1, 225);
		// zero half sizes
		run_phase(0, 16384, 0, 4095, 225);
		run_phase(0, -16384, 4095, 0, 225);
		run_phase(11585, 11585, 320, 240, 225);
		run_phase($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
			$urandom_range(1, 4095), $urandom_range(1, 4095), 225);
		// out-of-range trig values and upper bits on the size registers
		run_phase($urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 65535), 225);
		run_phase(-32768, 32767, 65535, 61440 + $urandom_range(1, 4095), 225);

		repeat (CW + 16) @(posedge clk);
		if (err_cnt == 0 && screen_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
